// File: hdl/vad_pkg.sv
// ----------------------------------------------------------------------------
// vad_pkg: shared types and constants for the vector angle unit
// Item format between the front end, the queue and the back end, the
// fixed-point constants and the arctangent table for the CORDIC steps.
// ----------------------------------------------------------------------------
`default_nettype none

package vad_pkg;

   localparam int CORDIC_STEPS = 60;
   localparam int SQRT_STEPS   = 32;

   localparam logic [63:0] PI_Q60         = 64'h3243F6A8885A308D;
   localparam logic [63:0] QUARTER_PI_Q60 = 64'h0C90FDAA22168C23;
   localparam logic [23:0] DEG_MAX        = 24'd11796480;
   localparam logic [33:0] P32            = 34'(PI_Q60 >> 28);
   localparam logic [33:0] P32_HALF       = P32 / 34'd2;
   // floor(DEG_MAX * 2^40 / P32): degrees per radian step, scaled by 2^40
   localparam logic [29:0] DEG_RECIP      = 30'((64'(DEG_MAX) << 40) / 64'(P32));
   localparam logic signed [31:0] LIM_POS = 32'sd1073741824;
   localparam logic signed [31:0] LIM_NEG = -32'sd1073741824;

   typedef struct packed {
      logic               degen;
      logic signed [31:0] ax;
      logic signed [31:0] ay;
      logic signed [31:0] az;
      logic signed [31:0] bx;
      logic signed [31:0] by;
      logic signed [31:0] bz;
   } item_type;

   // shift the magnitude right, truncating toward zero, keep the sign
   function automatic logic signed [63:0] tshr(input logic signed [63:0] v,
                                               input logic [5:0] s);
      logic [63:0] m;
      logic [63:0] r;
      m = v[63] ? 64'(-v) : 64'(v);
      r = m >> s;
      return v[63] ? -$signed(r) : $signed(r);
   endfunction

   function automatic logic [63:0] odd_div(input logic [63:0] p, input int k);
      logic [63:0] q;
      case (k)
         0:  q = p;
         1:  q = p / 64'd3;
         2:  q = p / 64'd5;
         3:  q = p / 64'd7;
         4:  q = p / 64'd9;
         5:  q = p / 64'd11;
         6:  q = p / 64'd13;
         7:  q = p / 64'd15;
         8:  q = p / 64'd17;
         9:  q = p / 64'd19;
         10: q = p / 64'd21;
         11: q = p / 64'd23;
         12: q = p / 64'd25;
         13: q = p / 64'd27;
         14: q = p / 64'd29;
         15: q = p / 64'd31;
         16: q = p / 64'd33;
         17: q = p / 64'd35;
         18: q = p / 64'd37;
         19: q = p / 64'd39;
         20: q = p / 64'd41;
         21: q = p / 64'd43;
         22: q = p / 64'd45;
         23: q = p / 64'd47;
         24: q = p / 64'd49;
         25: q = p / 64'd51;
         26: q = p / 64'd53;
         27: q = p / 64'd55;
         28: q = p / 64'd57;
         29: q = p / 64'd59;
         default: q = 64'd0;
      endcase
      return q;
   endfunction

   // arctangent of 2^-i in Q.60 radians, from the odd power series
   function automatic logic signed [63:0] atan_entry(input int i);
      logic signed [63:0] acc;
      logic [63:0]        t;
      int                 e;
      acc = 64'sd0;
      if (i == 0) begin
         acc = $signed(QUARTER_PI_Q60);
      end else begin
         for (int k = 0; k < 30; k++) begin
            e = i * (2 * k + 1);
            if (e <= 60) begin
               t = odd_div(64'd1 << (60 - e), k);
               if ((k & 1) != 0) acc = acc - $signed(t);
               else acc = acc + $signed(t);
            end
         end
      end
      return acc;
   endfunction

endpackage

`default_nettype wire

// File: hdl/vad_front.sv
// ----------------------------------------------------------------------------
// vad_front: command intake and classification
// Takes a vector pair, flags a zero vector and scales oversized vectors
// down by one bit, then hands the item to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module vad_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic signed [31:0] req_ax,
   input  wire logic signed [31:0] req_ay,
   input  wire logic signed [31:0] req_az,
   input  wire logic signed [31:0] req_bx,
   input  wire logic signed [31:0] req_by,
   input  wire logic signed [31:0] req_bz,
   input  wire logic               q_full,
   output logic                    push,
   output vad_pkg::item_type       push_item
);

   logic              fr_valid_ff, fr_valid_in;
   vad_pkg::item_type fr_item_ff, fr_item_in;
   logic              accept;
   logic              a_big, b_big;

   function automatic logic is_big(input logic signed [31:0] v);
      return (v > vad_pkg::LIM_POS) || (v < vad_pkg::LIM_NEG);
   endfunction

   function automatic logic signed [31:0] half(input logic signed [31:0] v,
                                               input logic en);
      logic [32:0] m;
      logic [32:0] r;
      m = v[31] ? -{1'b1, v} : {1'b0, v};
      r = en ? (m >> 1) : m;
      return v[31] ? 32'(-$signed(r)) : 32'(r);
   endfunction

   assign busy   = fr_valid_ff & q_full;
   assign accept = start & ~busy;
   assign push   = fr_valid_ff & ~q_full;
   assign push_item = fr_item_ff;

   always_comb begin
      a_big = is_big(req_ax) | is_big(req_ay) | is_big(req_az);
      b_big = is_big(req_bx) | is_big(req_by) | is_big(req_bz);
      fr_item_in.degen = ((req_ax == 0) && (req_ay == 0) && (req_az == 0)) ||
                         ((req_bx == 0) && (req_by == 0) && (req_bz == 0));
      fr_item_in.ax = half(req_ax, a_big);
      fr_item_in.ay = half(req_ay, a_big);
      fr_item_in.az = half(req_az, a_big);
      fr_item_in.bx = half(req_bx, b_big);
      fr_item_in.by = half(req_by, b_big);
      fr_item_in.bz = half(req_bz, b_big);
      fr_valid_in   = accept | (fr_valid_ff & q_full);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fr_valid_ff <= 1'b0;
      end else begin
         fr_valid_ff <= fr_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         fr_item_ff <= fr_item_in;
      end
   end

endmodule

`default_nettype wire

// File: hdl/vad_queue.sv
// ----------------------------------------------------------------------------
// vad_queue: two-entry queue between front and back end
// Decouples intake from the arithmetic pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module vad_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire vad_pkg::item_type push_item,
   output logic                   full,
   output logic                   pop,
   output vad_pkg::item_type      pop_item
);

   vad_pkg::item_type mem_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        cnt_ff, cnt_in;

   assign full     = (cnt_ff == 2'd2);
   assign pop      = (cnt_ff != 2'd0);
   assign pop_item = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      cnt_in    = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// File: hdl/vad_back.sv
// ----------------------------------------------------------------------------
// vad_back: angle pipeline
// Dot and cross products, common scaling, square root of the cross norm,
// CORDIC atan2 and conversion from radians to degrees by reciprocal
// multiplication with one remainder correction.
// ----------------------------------------------------------------------------
`default_nettype none

module vad_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   input  wire vad_pkg::item_type in_item,
   output logic                   rsp_strobe,
   output logic [23:0]            rsp_angle_deg,
   output logic                   rsp_degenerate
);

   localparam int NS  = vad_pkg::SQRT_STEPS;
   localparam int NC  = vad_pkg::CORDIC_STEPS;
   localparam int LAT = 7 + NS + 1 + NC + 4;

   logic [LAT-1:0] vld_ff, vld_in;
   logic [LAT-1:0] dg_ff, dg_in;

   // products, sums, scaling
   logic signed [63:0] p_ff [9];
   logic signed [63:0] d_ff, c0_ff, c1_ff, c2_ff;
   logic [62:0]        md_ff, mc0_ff, mc1_ff, mc2_ff, mx_ff;
   logic [62:0]        md_in, mc0_in, mc1_in, mc2_in, mx_in;
   logic               dneg_ff, dneg_s_ff;
   logic [62:0]        md_s_ff, mc0_s_ff, mc1_s_ff, mc2_s_ff;
   logic [5:0]         sh_ff, sh_in;
   logic [30:0]        u0_ff, u1_ff, u2_ff;
   logic signed [31:0] dsh_ff, dsq_ff;
   logic [30:0]        dm;
   logic [61:0]        q0_ff, q1_ff, q2_ff;

   // square root
   logic [63:0]        sn_ff [NS+1];
   logic [63:0]        sr_ff [NS+1];
   logic signed [31:0] sd_ff [NS+1];
   logic [63:0]        sn_in [1:NS];
   logic [63:0]        sr_in [1:NS];
   logic [63:0]        sbit, trial;

   // cordic
   logic signed [63:0] cx_ff [NC+1];
   logic signed [63:0] cy_ff [NC+1];
   logic signed [63:0] cz_ff [NC+1];
   logic signed [63:0] cx_in [1:NC];
   logic signed [63:0] cy_in [1:NC];
   logic signed [63:0] cz_in [1:NC];
   logic signed [63:0] atan_w [NC];
   logic signed [63:0] cx0_in, cy0_in, cz0_in, dx;
   logic [31:0]        cm;

   // degrees conversion
   logic signed [63:0] zc;
   logic [33:0]        rr_ff, rr_in;
   logic [63:0]        qprod;
   logic [57:0]        nfull, qp;
   logic [23:0]        qe_ff, qe_in, qa_ff;
   logic [35:0]        nr_ff, nr_in, rem_ff, rem_in;
   logic [23:0]        ang_in;
   logic [23:0]        ang_ff;

   for (genvar g = 0; g < NC; g++) begin : g_atan
      localparam logic signed [63:0] ATAN_G = vad_pkg::atan_entry(g);
      assign atan_w[g] = ATAN_G;
   end

   function automatic logic [62:0] mag63(input logic signed [63:0] v);
      logic [63:0] m;
      m = v[63] ? 64'(-v) : 64'(v);
      return m[62:0];
   endfunction

   assign vld_in = {vld_ff[LAT-2:0], in_valid};
   assign dg_in  = {dg_ff[LAT-2:0], in_item.degen};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // scaling: magnitudes, their maximum and the common shift
   always_comb begin
      md_in  = mag63(d_ff);
      mc0_in = mag63(c0_ff);
      mc1_in = mag63(c1_ff);
      mc2_in = mag63(c2_ff);
      mx_in  = md_in;
      if (mc0_in > mx_in) mx_in = mc0_in;
      if (mc1_in > mx_in) mx_in = mc1_in;
      if (mc2_in > mx_in) mx_in = mc2_in;
      sh_in = 6'd0;
      for (int k = 31; k <= 62; k++) begin
         if (mx_ff[k]) sh_in = 6'(k - 30);
      end
      dm = 31'(md_s_ff >> sh_ff);
   end

   // square root, one result bit per stage
   always_comb begin
      sbit  = '0;
      trial = '0;
      for (int k = 0; k < NS; k++) begin
         sbit  = 64'd1 << (62 - 2 * k);
         trial = sr_ff[k] + sbit;
         if (sn_ff[k] >= trial) begin
            sn_in[k+1] = sn_ff[k] - trial;
            sr_in[k+1] = (sr_ff[k] >> 1) + sbit;
         end else begin
            sn_in[k+1] = sn_ff[k];
            sr_in[k+1] = sr_ff[k] >> 1;
         end
      end
   end

   // fold into the right half plane, then rotate toward y = 0
   always_comb begin
      cm = sr_ff[NS][31:0];
      dx = 64'(sd_ff[NS]);
      if (dx[63]) begin
         cx0_in = $signed({4'd0, cm, 28'd0});
         cy0_in = (-dx) <<< 28;
         cz0_in = $signed(vad_pkg::QUARTER_PI_Q60 << 1);
      end else begin
         cx0_in = dx <<< 28;
         cy0_in = $signed({4'd0, cm, 28'd0});
         cz0_in = 64'sd0;
      end
      for (int i = 0; i < NC; i++) begin
         if (!cy_ff[i][63]) begin
            cx_in[i+1] = cx_ff[i] + vad_pkg::tshr(cy_ff[i], 6'(i));
            cy_in[i+1] = cy_ff[i] - vad_pkg::tshr(cx_ff[i], 6'(i));
            cz_in[i+1] = cz_ff[i] + atan_w[i];
         end else begin
            cx_in[i+1] = cx_ff[i] - vad_pkg::tshr(cy_ff[i], 6'(i));
            cy_in[i+1] = cy_ff[i] + vad_pkg::tshr(cx_ff[i], 6'(i));
            cz_in[i+1] = cz_ff[i] - atan_w[i];
         end
      end
   end

   // radians to degrees: estimate the quotient by the scaled reciprocal of pi,
   // which lands on the exact quotient or one below it; the remainder decides
   always_comb begin
      zc = cz_ff[NC];
      if (zc[63]) zc = 64'sd0;
      else if (zc > $signed(vad_pkg::PI_Q60)) zc = $signed(vad_pkg::PI_Q60);
      rr_in = zc[61:28];

      qprod = 64'(rr_ff) * 64'(vad_pkg::DEG_RECIP) + (64'd1 << 39);
      qe_in = qprod[63:40];
      nfull = 58'(rr_ff) * 58'(vad_pkg::DEG_MAX) + 58'(vad_pkg::P32_HALF);
      nr_in = nfull[35:0];

      // the remainder is below twice the divisor, so 36 bits hold it
      qp     = 58'(qe_ff) * 58'(vad_pkg::P32);
      rem_in = nr_ff - qp[35:0];

      ang_in = qa_ff;
      if (rem_ff >= 36'(vad_pkg::P32)) ang_in = qa_ff + 24'd1;
      if (ang_in > vad_pkg::DEG_MAX) ang_in = vad_pkg::DEG_MAX;
      if (dg_ff[LAT-2]) ang_in = 24'd0;
   end

   always_ff @(posedge clock) begin
      dg_ff <= dg_in;

      p_ff[0] <= in_item.ax * in_item.bx;
      p_ff[1] <= in_item.ay * in_item.by;
      p_ff[2] <= in_item.az * in_item.bz;
      p_ff[3] <= in_item.ay * in_item.bz;
      p_ff[4] <= in_item.az * in_item.by;
      p_ff[5] <= in_item.az * in_item.bx;
      p_ff[6] <= in_item.ax * in_item.bz;
      p_ff[7] <= in_item.ax * in_item.by;
      p_ff[8] <= in_item.ay * in_item.bx;

      d_ff  <= p_ff[0] + p_ff[1] + p_ff[2];
      c0_ff <= p_ff[3] - p_ff[4];
      c1_ff <= p_ff[5] - p_ff[6];
      c2_ff <= p_ff[7] - p_ff[8];

      md_ff   <= md_in;
      mc0_ff  <= mc0_in;
      mc1_ff  <= mc1_in;
      mc2_ff  <= mc2_in;
      mx_ff   <= mx_in;
      dneg_ff <= d_ff[63];

      sh_ff     <= sh_in;
      md_s_ff   <= md_ff;
      mc0_s_ff  <= mc0_ff;
      mc1_s_ff  <= mc1_ff;
      mc2_s_ff  <= mc2_ff;
      dneg_s_ff <= dneg_ff;

      u0_ff  <= 31'(mc0_s_ff >> sh_ff);
      u1_ff  <= 31'(mc1_s_ff >> sh_ff);
      u2_ff  <= 31'(mc2_s_ff >> sh_ff);
      dsh_ff <= dneg_s_ff ? -$signed({1'b0, dm}) : $signed({1'b0, dm});

      q0_ff  <= u0_ff * u0_ff;
      q1_ff  <= u1_ff * u1_ff;
      q2_ff  <= u2_ff * u2_ff;
      dsq_ff <= dsh_ff;

      sn_ff[0] <= 64'(q0_ff) + 64'(q1_ff) + 64'(q2_ff);
      sr_ff[0] <= 64'd0;
      sd_ff[0] <= dsq_ff;
      for (int k = 1; k <= NS; k++) begin
         sn_ff[k] <= sn_in[k];
         sr_ff[k] <= sr_in[k];
         sd_ff[k] <= sd_ff[k-1];
      end

      cx_ff[0] <= cx0_in;
      cy_ff[0] <= cy0_in;
      cz_ff[0] <= cz0_in;
      for (int i = 1; i <= NC; i++) begin
         cx_ff[i] <= cx_in[i];
         cy_ff[i] <= cy_in[i];
         cz_ff[i] <= cz_in[i];
      end

      rr_ff  <= rr_in;
      qe_ff  <= qe_in;
      nr_ff  <= nr_in;
      rem_ff <= rem_in;
      qa_ff  <= qe_ff;

      ang_ff <= ang_in;
   end

   assign rsp_strobe     = vld_ff[LAT-1];
   assign rsp_angle_deg  = ang_ff;
   assign rsp_degenerate = dg_ff[LAT-1];

endmodule

`default_nettype wire

// File: hdl/vector_angle_degrees_unit.sv
// ----------------------------------------------------------------------------
// vector_angle_degrees_unit: angle between two 3-D vectors in degrees
// Takes one vector pair per cycle and returns the angle as unsigned Q8.16.
// ----------------------------------------------------------------------------
// Issue a pair with start whenever busy is low; one pair is taken every cycle
// and busy stays low in steady flow. Each result appears on rsp_* for exactly
// one cycle with rsp_strobe, in issue order; the receiver cannot stall, so it
// must capture every strobe. Each pair passes the intake and queue registers,
// then the arithmetic pipeline: 7 product and scaling stages, 32 square-root
// stages, the fold stage, 60 CORDIC stages and 4 degree conversion stages.
// A zero vector on either side returns angle 0 with rsp_degenerate set.
// ----------------------------------------------------------------------------
`default_nettype none

module vector_angle_degrees_unit (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic signed [31:0] req_ax,
   input  wire logic signed [31:0] req_ay,
   input  wire logic signed [31:0] req_az,
   input  wire logic signed [31:0] req_bx,
   input  wire logic signed [31:0] req_by,
   input  wire logic signed [31:0] req_bz,
   output logic                    rsp_strobe,
   output logic [23:0]             rsp_angle_deg,
   output logic                    rsp_degenerate
);

   logic              q_full;
   logic              push;
   logic              pop;
   vad_pkg::item_type push_item;
   vad_pkg::item_type pop_item;

   vad_front u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_ax    (req_ax),
      .req_ay    (req_ay),
      .req_az    (req_az),
      .req_bx    (req_bx),
      .req_by    (req_by),
      .req_bz    (req_bz),
      .q_full    (q_full),
      .push      (push),
      .push_item (push_item)
   );

   vad_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (pop),
      .pop_item  (pop_item)
   );

   vad_back u_back (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (pop),
      .in_item        (pop_item),
      .rsp_strobe     (rsp_strobe),
      .rsp_angle_deg  (rsp_angle_deg),
      .rsp_degenerate (rsp_degenerate)
   );

endmodule

`default_nettype wire

// File: hdl/vad_checker.sv
// ----------------------------------------------------------------------------
// vad_checker: port-level checks for the vector angle unit
// Watches the result channel and the busy flag over time.
// ----------------------------------------------------------------------------
`default_nettype none

module vad_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        busy,
   input wire logic        rsp_strobe,
   input wire logic [23:0] rsp_angle_deg,
   input wire logic        rsp_degenerate
);

   // a zero vector forces the angle to zero
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_degenerate |-> rsp_angle_deg == 24'd0)
      else $error("degenerate beat with nonzero angle");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_angle_deg <= 24'd11796480)
      else $error("angle beyond 180 degrees");

   // the pipeline never stalls, so intake stays open
   a_no_busy: assert property (@(posedge clock) disable iff (reset)
      1'b1 |-> !busy)
      else $error("busy raised");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_strobe)
      else $error("result beat right after reset");

endmodule

bind vector_angle_degrees_unit vad_checker u_vad_checker (
   .clock          (clock),
   .reset          (reset),
   .busy           (busy),
   .rsp_strobe     (rsp_strobe),
   .rsp_angle_deg  (rsp_angle_deg),
   .rsp_degenerate (rsp_degenerate)
);

`default_nettype wire

// File: tb/vector_angle_degrees_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_angle_degrees_checker: angle predictor and result scoreboard
// Watches the request and result channels, predicts the angle of every
// accepted vector pair and compares each result beat with the oldest one.
// ----------------------------------------------------------------------------
`default_nettype none

module vector_angle_degrees_checker (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic               busy,
   input  wire logic signed [31:0] req_ax,
   input  wire logic signed [31:0] req_ay,
   input  wire logic signed [31:0] req_az,
   input  wire logic signed [31:0] req_bx,
   input  wire logic signed [31:0] req_by,
   input  wire logic signed [31:0] req_bz,
   input  wire logic               rsp_strobe,
   input  wire logic [23:0]        rsp_angle_deg,
   input  wire logic               rsp_degenerate,
   output int                      fail_count,
   output int                      pending_count,
   output int                      result_count,
   output int                      degen_count
);

   typedef struct packed {
      logic [23:0] angle;
      logic        degen;
   } angle_result_type;

   localparam logic [63:0] HALF_TURN = 64'h3243F6A8885A308D;
   localparam logic [63:0] EIGHTH    = 64'h0C90FDAA22168C23;
   localparam longint unsigned FULL_DEG = 64'd11796480;

   angle_result_type angle_queue[$];
   logic signed [63:0] arctan_steps[60];

   function automatic logic [63:0] abs64(input logic signed [63:0] v);
      return v[63] ? 64'(-v) : 64'(v);
   endfunction

   function automatic logic signed [63:0] trunc_shift(input logic signed [63:0] v,
                                                      input int s);
      logic [63:0] m;
      m = abs64(v) >> s;
      return v[63] ? -$signed(m) : $signed(m);
   endfunction

   function automatic void scale_down(ref logic signed [63:0] v[3]);
      logic [63:0] m;
      int t;
      m = abs64(v[0]);
      t = 0;
      if (abs64(v[1]) > m) m = abs64(v[1]);
      if (abs64(v[2]) > m) m = abs64(v[2]);
      while ((m >> t) > 64'h40000000) t++;
      for (int i = 0; i < 3; i++) v[i] = trunc_shift(v[i], t);
   endfunction

   function automatic logic [63:0] int_sqrt(input logic [63:0] n);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic logic signed [63:0] rotate_atan2(input logic signed [63:0] yi,
                                                       input logic signed [63:0] xi);
      logic signed [63:0] x, y, z, nx;
      z = 0;
      if (xi < 0) begin
         x = yi; y = -xi; z = $signed(EIGHTH * 2);
      end else begin
         x = xi; y = yi;
      end
      x = x <<< 28;
      y = y <<< 28;
      for (int i = 0; i < 60; i++) begin
         if (y >= 0) begin
            nx = x + trunc_shift(y, i);
            y = y - trunc_shift(x, i);
            z = z + arctan_steps[i];
         end else begin
            nx = x - trunc_shift(y, i);
            y = y + trunc_shift(x, i);
            z = z - arctan_steps[i];
         end
         x = nx;
      end
      if (z < 0) z = 0;
      if (64'(z) > HALF_TURN) z = $signed(HALF_TURN);
      return z;
   endfunction

   function automatic angle_result_type predict_angle(input logic signed [31:0] p[6]);
      logic signed [63:0] a[3], b[3], c[3], d;
      logic [63:0] m, csq, u, r32, p32, deg;
      angle_result_type res;
      int s;
      for (int i = 0; i < 3; i++) begin
         a[i] = p[i];
         b[i] = p[3 + i];
      end
      res = '0;
      if ((a[0] == 0 && a[1] == 0 && a[2] == 0) || (b[0] == 0 && b[1] == 0 && b[2] == 0)) begin
         res.degen = 1'b1;
         return res;
      end
      scale_down(a);
      scale_down(b);
      d = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
      c[0] = a[1] * b[2] - a[2] * b[1];
      c[1] = a[2] * b[0] - a[0] * b[2];
      c[2] = a[0] * b[1] - a[1] * b[0];
      m = abs64(d);
      for (int i = 0; i < 3; i++) if (abs64(c[i]) > m) m = abs64(c[i]);
      s = 0;
      while ((m >> s) >= 64'h80000000) s++;
      d = trunc_shift(d, s);
      csq = 0;
      for (int i = 0; i < 3; i++) begin
         u = abs64(c[i]) >> s;
         csq = csq + u * u;
      end
      r32 = 64'(rotate_atan2($signed(int_sqrt(csq)), d)) >> 28;
      p32 = HALF_TURN >> 28;
      deg = (r32 * FULL_DEG + p32 / 2) / p32;
      if (deg > FULL_DEG) deg = FULL_DEG;
      res.angle = deg[23:0];
      return res;
   endfunction

   initial begin
      logic signed [63:0] acc;
      longint e;
      arctan_steps[0] = $signed(EIGHTH);
      for (int i = 1; i < 60; i++) begin
         acc = 0;
         for (int k = 0; ; k++) begin
            e = i * (2 * k + 1);
            if (e > 60) break;
            if (k & 1) acc = acc - $signed((64'd1 << (60 - e)) / (2 * k + 1));
            else acc = acc + $signed((64'd1 << (60 - e)) / (2 * k + 1));
         end
         arctan_steps[i] = acc;
      end
   end

   assign pending_count = angle_queue.size();

   initial begin
      fail_count = 0;
      result_count = 0;
      degen_count = 0;
   end

   always @(posedge clock) begin
      logic signed [31:0] pair[6];
      angle_result_type want;
      if (!reset) begin
         if (rsp_strobe) begin
            result_count <= result_count + 1;
            if (angle_queue.size() == 0) begin
               if (fail_count < 10) $display("unexpected result beat: angle %0d degenerate %0b",
                                             rsp_angle_deg, rsp_degenerate);
               fail_count <= fail_count + 1;
            end else begin
               want = angle_queue.pop_front();
               if (want.degen) degen_count <= degen_count + 1;
               if (want.angle !== rsp_angle_deg || want.degen !== rsp_degenerate) begin
                  if (fail_count < 10)
                     $display("mismatch: angle exp %0d got %0d, degenerate exp %0b got %0b",
                              want.angle, rsp_angle_deg, want.degen, rsp_degenerate);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (start && !busy) begin
            pair = '{req_ax, req_ay, req_az, req_bx, req_by, req_bz};
            angle_queue.push_back(predict_angle(pair));
         end
      end
   end

endmodule

`default_nettype wire

// File: tb/tb_vector_angle_degrees_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vector_angle_degrees_unit: stimulus and verdict for the angle unit
// Drives directed and random vector pairs under several idle patterns and
// reports the scoreboard result from the checker.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_vector_angle_degrees_unit;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [31:0] req_ax = 0, req_ay = 0, req_az = 0;
   logic signed [31:0] req_bx = 0, req_by = 0, req_bz = 0;
   logic rsp_strobe;
   logic [23:0] rsp_angle_deg;
   logic rsp_degenerate;
   int fail_count, pending_count, result_count, degen_count;
   int cycle_count = 0;
   int idle_pct = 0;

   vector_angle_degrees_unit DUT (.*);
   vector_angle_degrees_checker angle_check (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("FAIL");
         $finish;
      end
   end

   function automatic logic signed [31:0] pick_component(input int mode);
      case (mode)
         0: return $signed($urandom);
         1: return $signed($urandom_range(0, 2000)) - 1000;
         2: return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
         3: return $signed($urandom_range(0, 65535) << 16);
         default: return 0;
      endcase
   endfunction

   // hold the beat until taken; random gaps before it, start stays high after
   task automatic send_pair(input logic signed [31:0] p[6]);
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      {req_ax, req_ay, req_az} <= {p[0], p[1], p[2]};
      {req_bx, req_by, req_bz} <= {p[3], p[4], p[5]};
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic send_random(input int count);
      logic signed [31:0] p[6];
      int mode;
      for (int n = 0; n < count; n++) begin
         mode = $urandom_range(0, 9);
         for (int i = 0; i < 6; i++) begin
            if (mode < 5) p[i] = pick_component(0);
            else if (mode < 7) p[i] = pick_component(1);
            else if (mode == 7) p[i] = pick_component($urandom_range(0, 4));
            else p[i] = pick_component(3);
         end
         // b takes the components of a, each with its own random sign
         if (mode == 9) for (int i = 0; i < 3; i++)
            p[3 + i] = $urandom_range(0, 1) ? p[i] : -p[i];
         if ($urandom_range(0, 40) == 0) for (int i = 0; i < 3; i++) p[i] = 0;
         send_pair(p);
      end
   endtask

   initial begin
      logic signed [31:0] p[6];
      logic signed [31:0] mx, mn;
      mx = 32'sh7FFFFFFF;
      mn = 32'sh80000000;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // zero vectors, extremes, parallel, antiparallel, orthogonal, scaled-down
      p = '{0, 0, 0, 0, 0, 0};                    send_pair(p);
      p = '{0, 0, 0, 65536, 0, 0};                send_pair(p);
      p = '{65536, 0, 0, 0, 0, 0};                send_pair(p);
      p = '{65536, 0, 0, 65536, 0, 0};            send_pair(p);
      p = '{65536, 0, 0, -65536, 0, 0};           send_pair(p);
      p = '{65536, 0, 0, 0, 65536, 0};            send_pair(p);
      p = '{0, 0, 65536, 0, 65536, 0};            send_pair(p);
      p = '{mx, mx, mx, mx, mx, mx};              send_pair(p);
      p = '{mn, mn, mn, mx, mx, mx};              send_pair(p);
      p = '{mn, mn, mn, mn, mn, mn};              send_pair(p);
      p = '{mn, 0, 0, 0, mx, 0};                  send_pair(p);
      p = '{1, 0, 0, 1, 1, 0};                    send_pair(p);
      p = '{1, 0, 0, -1, 0, 0};                   send_pair(p);
      p = '{32'sh40000001, 3, -3, 7, 32'sh7FFFFFFE, 1}; send_pair(p);
      p = '{mx, 1, 0, mx, 0, 1};                  send_pair(p);
      p = '{-1, -1, -1, 1, 1, 1};                 send_pair(p);
      p = '{32'sh55555555, 32'shAAAAAAAA, 0, 32'shAAAAAAAA, 32'sh55555555, 0};
      send_pair(p);
      // drain before the random phases
      start <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      idle_pct = 0;  send_random(500);
      idle_pct = 64; send_random(400);
      start <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      idle_pct = 34; send_random(400);
      idle_pct = 0;  send_random(400);
      start <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      $display("Covered %0d result beats (%0d degenerate) over directed extremes and",
               result_count, degen_count);
      $display("random pairs with sender gaps of 0, 34 and 64 percent.");
      if (fail_count == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule

`default_nettype wire
